// ===== hw/rtl/plrw_pkg.sv =====
// Package for the polyline rasterizer with masked writes.
// Holds operation codes, register indexes and result types; no dependencies.
package plrw_pkg;
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] CSR_COLOR = 2'd0;
   localparam logic [1:0] CSR_MASK  = 2'd1;
   localparam logic [1:0] CSR_PLANE = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] x_coord;
      logic [7:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [7:0]  pixel_value;
      logic [7:0]  box_left;
      logic [7:0]  box_right;
      logic [7:0]  box_top;
      logic [7:0]  box_bottom;
      logic [16:0] box_area;
   } rsp_type;
endpackage

// ===== hw/rtl/plrw_req_if.sv =====
// Valid/ready channel interface carrying one input word.
// Depends on plrw_pkg.
interface plrw_req_if;
   logic              valid;
   logic              ready;
   plrw_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/plrw_rsp_if.sv =====
// Valid/ready channel interface carrying one result word.
// Depends on plrw_pkg.
interface plrw_rsp_if;
   logic              valid;
   logic              ready;
   plrw_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/plrw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module plrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/polyline_raster_masked_write.sv =====
// Polyline rasterizer top level: sequencer, pixel RAM, bounding box.
// Depends on plrw_pkg, plrw_req_if, plrw_rsp_if and plrw_ram.
//
// Usage: each word on req carries an operation and a point. A start word
// sets the last point and the box. A draw word writes the segment from the
// last point to the new vertex, one masked read-modify-write per pixel, into
// the plane chosen by the plane register. A read word returns one stored pixel.
// Every word returns one rsp word with the pixel (zero unless a read) and
// the bounding box with its area. Registers on the csr port are to be
// written only while the block is idle; the block does not enforce this.
// Sequence: a start or an unused operation goes straight to the result; a
// read addresses the RAM and then returns the stored pixel. A draw of n
// major-axis steps writes n+1 pixels, each with a RAM read and then a
// masked write. A slanted draw writes its end pixel first and advances the
// minor coordinate, tracked as a running quotient and remainder, before
// each further pixel.
// Throughput: one word at a time; the next word is taken in the cycle after
// the previous result is taken from the output register.
// Reset: the pixel RAM is swept to zero, one pixel per cycle over all
// PLANE_COUNT*WIDTH_PIXELS*HEIGHT_PIXELS addresses, during which req is held
// not ready; the configuration registers and the box reset at once.
// Stall: the result sits in an output register; the next word is taken
// once that register is free.
module polyline_raster_masked_write #(
   parameter int WIDTH_PIXELS  = 256,
   parameter int HEIGHT_PIXELS = 256,
   parameter int PLANE_COUNT   = 4
) (
   input  logic             clock,
   input  logic             reset,
   plrw_req_if.sink         req,
   plrw_rsp_if.source       rsp,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_write_data
);
   localparam int DEPTH = PLANE_COUNT * WIDTH_PIXELS * HEIGHT_PIXELS;
   localparam int AW = $clog2(DEPTH);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_WR    = 3'd4;
   localparam logic [2:0] ST_PEEK  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // Configuration registers.
   logic [7:0] color_ff, mask_ff;
   logic [1:0] plane_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= '0;
         mask_ff  <= 8'hFF;
         plane_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            plrw_pkg::CSR_COLOR: color_ff <= csr_write_data;
            plrw_pkg::CSR_MASK:  mask_ff  <= csr_write_data;
            plrw_pkg::CSR_PLANE: plane_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   logic [2:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [7:0]  last_x_ff, last_y_ff, left_ff, right_ff, top_ff, bottom_ff;
   logic [7:0]  last_x_in, last_y_in, left_in, right_in, top_in, bottom_in;
   plrw_pkg::rsp_type out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   // Segment walk: k runs over the major axis; point is the pixel to write.
   logic [8:0]  x0_ff, y0_ff, x0_in, y0_in;      // start point
   logic [8:0]  adx_ff, ady_ff, adx_in, ady_in;  // magnitudes
   logic        sx_ff, sy_ff, sx_in, sy_in;      // negative direction
   logic        xmaj_ff, xmaj_in, slant_ff, slant_in;
   logic [8:0]  k_ff, k_in, kend_ff, kend_in;
   logic        isread_ff, isread_in;
   logic signed [10:0] px_ff, py_ff, px_in, py_in;
   // Running floor(|dminor|*k / |dmajor|) as quotient and remainder.
   logic [8:0]  q_ff, q_in;
   logic [8:0]  rem_ff, rem_in;

   // RAM.
   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [7:0]    ram_wd, ram_rd;
   logic          pix_ok;
   logic [AW-1:0] pix_addr;

   plrw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   always_comb begin
      pix_ok = (int'(plane_ff) < PLANE_COUNT) && !px_ff[10] && !py_ff[10]
               && (int'(px_ff) < WIDTH_PIXELS) && (int'(py_ff) < HEIGHT_PIXELS);
      pix_addr = AW'(plane_ff) * AW'(WIDTH_PIXELS * HEIGHT_PIXELS)
                 + AW'(py_ff[9:0]) * AW'(WIDTH_PIXELS) + AW'(px_ff[9:0]);
   end

   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   logic [9:0]  qf;        // floor quotient incl. sign
   logic [9:0]  rem_sum;
   logic [8:0]  dminor;
   logic        neg_minor;
   logic [8:0]  bw, bh;
   plrw_pkg::rsp_type box;
   logic signed [10:0] minor_base;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff;
      last_x_in = last_x_ff; last_y_in = last_y_ff;
      left_in = left_ff; right_in = right_ff; top_in = top_ff; bottom_in = bottom_ff;
      out_in = out_ff; out_valid_in = out_valid_ff;
      x0_in = x0_ff; y0_in = y0_ff; adx_in = adx_ff; ady_in = ady_ff;
      sx_in = sx_ff; sy_in = sy_ff; xmaj_in = xmaj_ff; slant_in = slant_ff;
      k_in = k_ff; kend_in = kend_ff; isread_in = isread_ff;
      px_in = px_ff; py_in = py_ff;
      q_in = q_ff; rem_in = rem_ff;
      ram_we = 1'b0; ram_wa = pix_addr; ram_wd = '0; ram_ra = pix_addr;
      rem_sum = '0; dminor = '0; qf = '0; neg_minor = 1'b0; minor_base = '0;

      bw = 9'(right_ff) - 9'(left_ff) + 9'd1;
      bh = 9'(bottom_ff) - 9'(top_ff) + 9'd1;
      box.pixel_value = '0;
      box.box_left = left_ff; box.box_right = right_ff;
      box.box_top = top_ff; box.box_bottom = bottom_ff;
      box.box_area = 17'(18'(bw) * 18'(bh));

      if (rsp.valid && rsp.ready) out_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff[AW-1:0];
            clr_in = clr_ff + (AW+1)'(1);
            if (clr_ff == (AW+1)'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               isread_in = 1'b0;
               case (req.data.operation)
                  plrw_pkg::OP_START: begin
                     last_x_in = req.data.x_coord; last_y_in = req.data.y_coord;
                     left_in = req.data.x_coord; right_in = req.data.x_coord;
                     top_in = req.data.y_coord; bottom_in = req.data.y_coord;
                     state_in = ST_DONE;
                  end
                  plrw_pkg::OP_DRAW: begin
                     x0_in = {1'b0, last_x_ff}; y0_in = {1'b0, last_y_ff};
                     sx_in = req.data.x_coord < last_x_ff;
                     sy_in = req.data.y_coord < last_y_ff;
                     adx_in = sx_in ? 9'(last_x_ff) - 9'(req.data.x_coord)
                                    : 9'(req.data.x_coord) - 9'(last_x_ff);
                     ady_in = sy_in ? 9'(last_y_ff) - 9'(req.data.y_coord)
                                    : 9'(req.data.y_coord) - 9'(last_y_ff);
                     slant_in = (adx_in != 0) && (ady_in != 0);
                     xmaj_in = (adx_in > ady_in) || (ady_in == 0);
                     kend_in = xmaj_in ? adx_in : ady_in;
                     q_in = '0;
                     rem_in = '0;
                     if (slant_in) begin
                        px_in = 11'(req.data.x_coord); py_in = 11'(req.data.y_coord);
                        k_in = 9'd0;
                     end else begin
                        px_in = 11'(last_x_ff); py_in = 11'(last_y_ff);
                        k_in = 9'd0;
                     end
                     if (req.data.x_coord < left_ff) left_in = req.data.x_coord;
                     if (req.data.x_coord > right_ff) right_in = req.data.x_coord;
                     if (req.data.y_coord < top_ff) top_in = req.data.y_coord;
                     if (req.data.y_coord > bottom_ff) bottom_in = req.data.y_coord;
                     last_x_in = req.data.x_coord; last_y_in = req.data.y_coord;
                     state_in = ST_RD;
                  end
                  plrw_pkg::OP_READ: begin
                     isread_in = 1'b1;
                     px_in = 11'(req.data.x_coord); py_in = 11'(req.data.y_coord);
                     state_in = ST_PEEK;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_STEP: begin
            // Turn the running quotient into the signed floor offset and
            // form the next pixel of the slanted segment.
            neg_minor = xmaj_ff ? sy_ff : sx_ff;
            qf = neg_minor ? (10'd0 - {1'b0, q_ff} - ((rem_ff != 9'd0) ? 10'd1 : 10'd0))
                           : {1'b0, q_ff};
            minor_base = xmaj_ff ? 11'(y0_ff) : 11'(x0_ff);
            if (xmaj_ff) begin
               py_in = minor_base + {qf[9], qf};
               px_in = sx_ff ? 11'(x0_ff) - 11'(k_ff) : 11'(x0_ff) + 11'(k_ff);
            end else begin
               px_in = minor_base + {qf[9], qf};
               py_in = sy_ff ? 11'(y0_ff) - 11'(k_ff) : 11'(y0_ff) + 11'(k_ff);
            end
            state_in = ST_RD;
         end
         ST_RD: begin
            ram_ra = pix_addr;
            state_in = ST_WR;
         end
         ST_WR: begin
            ram_we = pix_ok;
            ram_wa = pix_addr;
            ram_wd = (ram_rd & ~mask_ff) | (color_ff & mask_ff);
            if (slant_ff) begin
               if (k_ff == kend_ff) begin
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + 9'd1;
                  // The minor delta never exceeds the major one, so the
                  // quotient grows by at most one per step.
                  dminor = xmaj_ff ? ady_ff : adx_ff;
                  rem_sum = {1'b0, rem_ff} + {1'b0, dminor};
                  if (rem_sum >= {1'b0, kend_ff}) begin
                     rem_in = 9'(rem_sum - {1'b0, kend_ff});
                     q_in = q_ff + 9'd1;
                  end else begin
                     rem_in = rem_sum[8:0];
                  end
                  state_in = ST_STEP;
               end
            end else begin
               if (k_ff == kend_ff) begin
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + 9'd1;
                  if (adx_ff != 0) px_in = sx_ff ? px_ff - 11'd1 : px_ff + 11'd1;
                  else py_in = sy_ff ? py_ff - 11'd1 : py_ff + 11'd1;
                  state_in = ST_RD;
               end
            end
         end
         ST_PEEK: begin
            ram_ra = pix_addr;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            out_in = box;
            out_in.pixel_value = (isread_ff && pix_ok) ? ram_rd : 8'd0;
            out_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; out_valid_ff <= 1'b0;
         last_x_ff <= '0; last_y_ff <= '0;
         left_ff <= '0; right_ff <= '0; top_ff <= '0; bottom_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; out_valid_ff <= out_valid_in;
         last_x_ff <= last_x_in; last_y_ff <= last_y_in;
         left_ff <= left_in; right_ff <= right_in; top_ff <= top_in;
         bottom_ff <= bottom_in;
      end
      out_ff <= out_in;
      x0_ff <= x0_in; y0_ff <= y0_in; adx_ff <= adx_in; ady_ff <= ady_in;
      sx_ff <= sx_in; sy_ff <= sy_in; xmaj_ff <= xmaj_in; slant_ff <= slant_in;
      k_ff <= k_in; kend_ff <= kend_in;
      isread_ff <= isread_in; px_ff <= px_in; py_ff <= py_in;
      q_ff <= q_in; rem_ff <= rem_in;
   end

`ifndef NO_ASSERTIONS
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready) else $error("ready during clear");
   a_done_gives_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> out_valid_ff) else $error("result lost");
   a_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> $past(state_ff) == ST_RD) else $error("write w/o read");
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (left_ff <= right_ff && top_ff <= bottom_ff))
      else $error("box inverted");
`endif
endmodule
